// ===== design/ssfs_pkg.sv =====
// Shared types, constants and the glyph table for the frame sequencer.
`default_nettype none

package ssfs_pkg;

    localparam int DIGIT_SLOTS = 6;
    localparam int GLYPH_COUNT = 47;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OP_W    = 4;
    localparam int DIGIT_W = 3;
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 3;
    localparam int MAP_W   = 18;
    localparam int SEG_W   = 8;
    localparam int POS_W   = 3;
    localparam int STEP_W  = 5;
    localparam int LEVEL_W = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_CHAR     = 4'd0;
    localparam logic [OP_W-1:0] OP_RAW      = 4'd1;
    localparam logic [OP_W-1:0] OP_DP       = 4'd2;
    localparam logic [OP_W-1:0] OP_INT8     = 4'd3;
    localparam logic [OP_W-1:0] OP_INT12    = 4'd4;
    localparam logic [OP_W-1:0] OP_INT16    = 4'd5;
    localparam logic [OP_W-1:0] OP_BRIGHT   = 4'd6;
    localparam logic [OP_W-1:0] OP_OFF      = 4'd7;
    localparam logic [OP_W-1:0] OP_TEST_ON  = 4'd8;
    localparam logic [OP_W-1:0] OP_TEST_OFF = 4'd9;
    localparam logic [OP_W-1:0] OP_CLEAR    = 4'd10;

    // configuration register indexes
    localparam logic REG_DIGIT_COUNT = 1'b0;
    localparam logic REG_DIGIT_MAP   = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;
    localparam logic [MAP_W-1:0]   MAP_RESET   = 18'd181896;

    // link bytes
    localparam logic [SEG_W-1:0] CMD_FIXED = 8'h44;
    localparam logic [SEG_W-1:0] CMD_AUTO  = 8'h40;
    localparam logic [SEG_W-1:0] ADDR_BASE = 8'hC0;
    localparam logic [SEG_W-1:0] CMD_ON    = 8'h88;
    localparam logic [SEG_W-1:0] CMD_OFF   = 8'h80;
    localparam logic [SEG_W-1:0] DP_BIT    = 8'h80;
    localparam logic [SEG_W-1:0] SEG_MASK  = 8'h7F;
    localparam logic [SEG_W-1:0] TEST_BYTE = 8'hFF;
    localparam logic [5:0]       BLANK_INDEX = 6'd32;

    // number clipping limits
    localparam logic [VALUE_W-1:0] DEC_MAX2 = 16'd99;
    localparam logic [VALUE_W-1:0] DEC_MAX3 = 16'd999;
    localparam logic [VALUE_W-1:0] DEC_MAX4 = 16'd9999;
    localparam logic [VALUE_W-1:0] HEX_MAX2 = 16'h00FF;
    localparam logic [VALUE_W-1:0] HEX_MAX3 = 16'h0FFF;
    localparam logic [VALUE_W-1:0] HEX_MAX4 = 16'hFFFF;

    // floor(x/10) = (x * 6554) >> 16 for x below 16384
    localparam logic [12:0] DEC_RECIP = 13'd6554;

    typedef enum logic [1:0] {
        K_CMD   = 2'd0,   // one-byte command frame
        K_DATA  = 2'd1,   // address byte then segment byte
        K_TADDR = 2'd2,   // test frame address byte
        K_TBYTE = 2'd3    // test frame data byte
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [SEG_W-1:0] data;
        logic [POS_W-1:0] pos;
        logic             tlast;
        logic             run_last;
    } job_t;

    function automatic logic [SEG_W-1:0] glyph_rom(input logic [5:0] idx);
        logic [SEG_W-1:0] g;
        case (idx)
            6'd0:  g = 8'h3f;
            6'd1:  g = 8'h06;
            6'd2:  g = 8'h5b;
            6'd3:  g = 8'h4f;
            6'd4:  g = 8'h66;
            6'd5:  g = 8'h6d;
            6'd6:  g = 8'h7d;
            6'd7:  g = 8'h07;
            6'd8:  g = 8'h7f;
            6'd9:  g = 8'h67;
            6'd10: g = 8'h77;
            6'd11: g = 8'h7c;
            6'd12: g = 8'h39;
            6'd13: g = 8'h5e;
            6'd14: g = 8'h79;
            6'd15: g = 8'h71;
            6'd16: g = 8'h58;
            6'd17: g = 8'h6f;
            6'd18: g = 8'h74;
            6'd19: g = 8'h76;
            6'd20: g = 8'h10;
            6'd21: g = 8'h30;
            6'd22: g = 8'h1e;
            6'd23: g = 8'h38;
            6'd24: g = 8'h54;
            6'd25: g = 8'h37;
            6'd26: g = 8'h73;
            6'd27: g = 8'h50;
            6'd28: g = 8'h78;
            6'd29: g = 8'h1c;
            6'd30: g = 8'h3e;
            6'd31: g = 8'h6e;
            6'd32: g = 8'h00;
            6'd33: g = 8'h01;
            6'd34: g = 8'h40;
            6'd35: g = 8'h08;
            6'd36: g = 8'h63;
            6'd37: g = 8'h5c;
            6'd38: g = 8'h46;
            6'd39: g = 8'h70;
            6'd40: g = 8'h01;
            6'd41: g = 8'h02;
            6'd42: g = 8'h04;
            6'd43: g = 8'h08;
            6'd44: g = 8'h10;
            6'd45: g = 8'h20;
            6'd46: g = 8'h40;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    function automatic logic [POS_W-1:0] map_pos(input logic [MAP_W-1:0] map,
                                                 input logic [DIGIT_W-1:0] idx);
        logic [POS_W-1:0] p;
        case (idx)
            3'd0:    p = map[2:0];
            3'd1:    p = map[5:3];
            3'd2:    p = map[8:6];
            3'd3:    p = map[11:9];
            3'd4:    p = map[14:12];
            3'd5:    p = map[17:15];
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== design/ssfs_op_if.sv =====
// Handshake channel carrying one display operation.
`default_nettype none

interface ssfs_op_if import ssfs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] value;
    logic               use_decimal;
    logic               dp_on;

    modport source (output valid, operation, digit, value, use_decimal, dp_on,
                    input ready);
    modport sink   (input valid, operation, digit, value, use_decimal, dp_on,
                    output ready);
endinterface

`default_nettype wire

// ===== design/ssfs_byte_if.sv =====
// Handshake channel carrying one link byte with its frame marks.
`default_nettype none

interface ssfs_byte_if import ssfs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] wire_byte;
    logic             frame_first;
    logic             frame_last;
    logic             run_last;

    modport source (output valid, wire_byte, frame_first, frame_last, run_last,
                    input ready);
    modport sink   (input valid, wire_byte, frame_first, frame_last, run_last,
                    output ready);
endinterface

`default_nettype wire

// ===== design/ssfs_front.sv =====
// Front end: takes operations, updates the shadow segments, queues frame jobs.
`default_nettype none

module ssfs_front import ssfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] digit_count,
    input  logic [MAP_W-1:0]   digit_map,
    ssfs_op_if.sink            op_chan,
    output logic               push,
    output job_t               push_job,
    input  logic               full
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_CONV   = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg;
    logic [DIGIT_W-1:0]  digit_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                dec_reg;
    logic                dp_reg;
    logic [VALUE_W-1:0]  num_reg, num_next;
    logic [1:0]          conv_reg, conv_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [STEP_W-1:0]   last_step_reg, last_step_next;
    logic [LEVEL_W-1:0]  bright_reg, bright_next;
    logic [SEG_W-1:0]    seg_reg [DIGIT_SLOTS];

    logic                accept;
    logic [DIGIT_W-1:0]  ndig;
    logic [DIGIT_W-1:0]  slot;
    logic [DIGIT_W-1:0]  emit_idx;
    logic [DIGIT_W-1:0]  rd_idx;
    logic [SEG_W-1:0]    rd_seg;
    logic                wr_en;
    logic [DIGIT_W-1:0]  wr_idx;
    logic [SEG_W-1:0]    wr_data;
    logic [VALUE_W-1:0]  clip;
    logic [26:0]         prod;
    logic [VALUE_W-1:0]  quot;
    logic [3:0]          rem;
    logic [13:0]         q_times10;
    logic [5:0]          gidx;
    logic                is_last;
    logic                num_ok;

    assign op_chan.ready = (state_reg == ST_IDLE);
    assign accept        = op_chan.valid && op_chan.ready;

    assign ndig   = 3'(op_reg - 4'd1);
    assign slot   = 3'(digit_reg + ndig - 3'd1 - {1'b0, conv_reg});
    assign num_ok = ({1'b0, digit_reg} + {1'b0, ndig}) <= {1'b0, digit_count};
    assign is_last = (step_reg == last_step_reg);

    // one shared read port on the shadow segments
    always_comb
    begin
        case (state_reg)
            ST_CONV:  rd_idx = slot;
            ST_EMIT:  rd_idx = emit_idx;
            default:  rd_idx = digit_reg;
        endcase
    end

    assign rd_seg = (rd_idx < DIGIT_W'(DIGIT_SLOTS)) ? seg_reg[rd_idx] : '0;

    // clip limit for number operations
    always_comb
    begin
        case (ndig)
            3'd2:    clip = dec_reg ? DEC_MAX2 : HEX_MAX2;
            3'd3:    clip = dec_reg ? DEC_MAX3 : HEX_MAX3;
            default: clip = dec_reg ? DEC_MAX4 : HEX_MAX4;
        endcase
    end

    // one digit per cycle: reciprocal multiply for decimal, nibble for hex
    assign prod      = num_reg[13:0] * DEC_RECIP;
    assign q_times10 = {prod[26:16], 3'b000} + {2'b00, prod[26:16], 1'b0};
    always_comb
    begin
        if (dec_reg)
        begin
            quot = {5'b0, prod[26:16]};
            rem  = 4'(num_reg[13:0] - q_times10);
        end
        else
        begin
            quot = {4'b0, num_reg[VALUE_W-1:4]};
            rem  = num_reg[3:0];
        end
    end

    assign gidx = (value_reg < VALUE_W'(GLYPH_COUNT)) ? value_reg[5:0] : BLANK_INDEX;

    // job for the current emit step
    always_comb
    begin
        push_job          = '0;
        push_job.kind     = K_CMD;
        push_job.data     = CMD_FIXED;
        push_job.run_last = is_last;
        emit_idx          = digit_reg;
        case (op_reg)
            OP_CHAR, OP_RAW, OP_DP:
            begin
                if (step_reg != '0)
                begin
                    push_job.kind = K_DATA;
                    push_job.data = rd_seg;
                end
            end
            OP_INT8, OP_INT12, OP_INT16:
            begin
                emit_idx = 3'(digit_reg + step_reg[2:0] - 3'd1);
                if (step_reg != '0)
                begin
                    push_job.kind = K_DATA;
                    push_job.data = rd_seg;
                end
            end
            OP_BRIGHT:
                push_job.data = CMD_ON + {5'b0, bright_reg};
            OP_OFF:
                push_job.data = CMD_OFF;
            OP_TEST_ON, OP_TEST_OFF:
            begin
                emit_idx = 3'(step_reg[2:0] - 3'd2);
                if (step_reg == 5'd0)
                    push_job.data = CMD_AUTO;
                else if (step_reg == 5'd1)
                    push_job.kind = K_TADDR;
                else
                begin
                    push_job.kind  = K_TBYTE;
                    push_job.data  = (op_reg == OP_TEST_ON) ? TEST_BYTE : rd_seg;
                    push_job.tlast = is_last;
                end
            end
            OP_CLEAR:
            begin
                emit_idx = step_reg[4:2];
                if (step_reg[0])
                begin
                    push_job.kind = K_DATA;
                    // first pass keeps the point, second pass blanks everything
                    push_job.data = step_reg[1] ? '0 : (rd_seg & DP_BIT);
                end
            end
            default:
                push_job.data = CMD_FIXED;
        endcase
        push_job.pos = map_pos(digit_map, emit_idx);
    end

    assign push = (state_reg == ST_EMIT) && !full;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        conv_next      = conv_reg;
        step_next      = step_reg;
        last_step_next = last_step_reg;
        bright_next    = bright_reg;
        wr_en          = 1'b0;
        wr_idx         = digit_reg;
        wr_data        = rd_seg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                step_next  = '0;
                state_next = ST_EMIT;
                case (op_reg)
                    OP_CHAR, OP_RAW, OP_DP:
                    begin
                        last_step_next = 5'd1;
                        if (digit_reg < digit_count)
                        begin
                            wr_en = 1'b1;
                            if (op_reg == OP_CHAR)
                                wr_data = glyph_rom(gidx) | (rd_seg & DP_BIT);
                            else if (op_reg == OP_RAW)
                                wr_data = (value_reg[SEG_W-1:0] & SEG_MASK)
                                          | (rd_seg & DP_BIT);
                            else
                                wr_data = (rd_seg & SEG_MASK) | (dp_reg ? DP_BIT : '0);
                        end
                        else
                            state_next = ST_IDLE;
                    end
                    OP_INT8, OP_INT12, OP_INT16:
                    begin
                        last_step_next = {2'b00, ndig};
                        num_next       = (value_reg > clip) ? clip : value_reg;
                        conv_next      = '0;
                        state_next     = num_ok ? ST_CONV : ST_IDLE;
                    end
                    OP_BRIGHT:
                    begin
                        last_step_next = '0;
                        bright_next    = value_reg[LEVEL_W-1:0];
                    end
                    OP_OFF:
                        last_step_next = '0;
                    OP_TEST_ON, OP_TEST_OFF:
                        last_step_next = 5'({2'b00, digit_count} + 5'd1);
                    OP_CLEAR:
                        last_step_next = 5'({digit_count, 2'b00} - 5'd1);
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_CONV:
            begin
                // least significant digit lands in the rightmost slot first
                wr_en     = 1'b1;
                wr_idx    = slot;
                wr_data   = (rd_seg & DP_BIT) | (glyph_rom({2'b00, rem}) & SEG_MASK);
                num_next  = quot;
                conv_next = 2'(conv_reg + 2'd1);
                if ({1'b0, conv_reg} == 3'(ndig - 3'd1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (push)
                begin
                    if (op_reg == OP_CLEAR && step_reg[1:0] == 2'b11)
                    begin
                        wr_en   = 1'b1;
                        wr_idx  = emit_idx;
                        wr_data = '0;
                    end
                    if (is_last)
                        state_next = ST_IDLE;
                    else
                        step_next = 5'(step_reg + 5'd1);
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            bright_reg <= '0;
            for (int i = 0; i < DIGIT_SLOTS; i++)
                seg_reg[i] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            bright_reg <= bright_next;
            if (wr_en && (wr_idx < DIGIT_W'(DIGIT_SLOTS)))
                seg_reg[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_chan.operation;
            digit_reg <= op_chan.digit;
            value_reg <= op_chan.value;
            dec_reg   <= op_chan.use_decimal;
            dp_reg    <= op_chan.dp_on;
        end
        num_reg       <= num_next;
        conv_reg      <= conv_next;
        step_reg      <= step_next;
        last_step_reg <= last_step_next;
    end

endmodule

`default_nettype wire

// ===== design/ssfs_queue.sv =====
// Short job queue between the front end and the byte sequencer.
`default_nettype none

module ssfs_queue import ssfs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            if (do_pop)
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            if (do_push && !do_pop)
                count_reg <= QCNT_W'(count_reg + 1'b1);
            else if (do_pop && !do_push)
                count_reg <= QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ===== design/ssfs_back.sv =====
// Back end: expands queued jobs into link bytes with frame marks.
`default_nettype none

module ssfs_back import ssfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    output logic         pop,
    input  job_t         pop_job,
    input  logic         empty,
    ssfs_byte_if.source  byte_chan
);

    job_t cur_reg;
    logic cur_valid_reg;
    logic beat_reg;
    logic fire;
    logic final_beat;

    assign final_beat = (cur_reg.kind != K_DATA) || beat_reg;
    assign fire       = byte_chan.valid && byte_chan.ready;
    assign pop        = !empty && (!cur_valid_reg || (fire && final_beat));

    assign byte_chan.valid    = cur_valid_reg;
    assign byte_chan.run_last = cur_reg.run_last && final_beat;

    always_comb
    begin
        case (cur_reg.kind)
            K_CMD:
            begin
                byte_chan.wire_byte   = cur_reg.data;
                byte_chan.frame_first = 1'b1;
                byte_chan.frame_last  = 1'b1;
            end
            K_DATA:
            begin
                byte_chan.wire_byte   = beat_reg ? cur_reg.data
                                                 : (ADDR_BASE | {5'b0, cur_reg.pos});
                byte_chan.frame_first = !beat_reg;
                byte_chan.frame_last  = beat_reg;
            end
            K_TADDR:
            begin
                byte_chan.wire_byte   = ADDR_BASE;
                byte_chan.frame_first = 1'b1;
                byte_chan.frame_last  = 1'b0;
            end
            K_TBYTE:
            begin
                byte_chan.wire_byte   = cur_reg.data;
                byte_chan.frame_first = 1'b0;
                byte_chan.frame_last  = cur_reg.tlast;
            end
            default:
            begin
                byte_chan.wire_byte   = cur_reg.data;
                byte_chan.frame_first = 1'b0;
                byte_chan.frame_last  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            beat_reg      <= 1'b0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            beat_reg      <= 1'b0;
        end
        else if (fire)
        begin
            if (final_beat)
                cur_valid_reg <= 1'b0;
            else
                beat_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= pop_job;
    end

endmodule

`default_nettype wire

// ===== design/seven_segment_frame_sequencer.sv =====
// Top level: configuration registers, front end, job queue and byte sequencer.
//
//  channel     dir  handshake            payload
//  op_chan     in   valid/ready          operation, digit, value, use_decimal, dp_on
//  byte_chan   out  valid/ready          wire_byte, frame_first, frame_last, run_last
//  cfg         in   cfg_wr_en            cfg_index, cfg_data
//
// An operation holds the front end through accept, decode, one conversion step per
// number digit (up to 4) and one emit step per queued frame job (up to 24 for
// clear), while the 4-entry job queue has room. Bytes leave at one beat per cycle
// while jobs wait and byte_chan is ready; a data frame job yields two beats.
// A full queue stalls the front end; the byte sequencer stalls only on byte_chan.
// Reset: all digits blank, brightness 0, one digit in use, identity digit map.
`default_nettype none

module seven_segment_frame_sequencer import ssfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [MAP_W-1:0] cfg_data,
    ssfs_op_if.sink          op_chan,
    ssfs_byte_if.source      byte_chan
);

    logic [COUNT_W-1:0] digit_count_reg;
    logic [MAP_W-1:0]   digit_map_reg;
    logic [COUNT_W-1:0] count_wr;

    logic push;
    job_t push_job;
    logic full;
    logic pop;
    job_t pop_job;
    logic empty;

    assign count_wr = ((cfg_data[COUNT_W-1:0] != '0) &&
                       (cfg_data[COUNT_W-1:0] <= COUNT_W'(DIGIT_SLOTS)))
                      ? cfg_data[COUNT_W-1:0] : COUNT_RESET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= COUNT_RESET;
            digit_map_reg   <= MAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DIGIT_COUNT: digit_count_reg <= count_wr;
                REG_DIGIT_MAP:   digit_map_reg   <= cfg_data;
                default:         digit_map_reg   <= digit_map_reg;
            endcase
        end
    end

    ssfs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .digit_count (digit_count_reg),
        .digit_map   (digit_map_reg),
        .op_chan     (op_chan),
        .push        (push),
        .push_job    (push_job),
        .full        (full)
    );

    ssfs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    ssfs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_job   (pop_job),
        .empty     (empty),
        .byte_chan (byte_chan)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_count_reg != '0) && (digit_count_reg <= COUNT_W'(DIGIT_SLOTS)))
        else $error("digit count out of range");

    a_run_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_chan.valid && byte_chan.run_last) |-> byte_chan.frame_last)
        else $error("operation ended inside a frame");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
